// ===== src/bpcs_pkg.sv =====
`default_nettype none
package bpcs_pkg;

  localparam int CoordWidth = 16;
  localparam int RadWidth   = 15;
  localparam int DiffWidth  = CoordWidth + 2;
  localparam int SqWidth    = 2 * DiffWidth;
  localparam int Dist2Width = SqWidth + 2;
  localparam int DotWidth   = SqWidth + 2;
  // operands of the cylinder compare fit 34 bits, multiplied as 17-bit halves
  localparam int MulWidth   = 34;
  localparam int HalfWidth  = MulWidth / 2;
  localparam int ProdWidth  = 2 * MulWidth;

  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = CoordWidth;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic [1:0]                   mark_t;

  localparam mark_t MarkNone      = 2'd0;
  localparam mark_t MarkCleaned   = 2'd1;
  localparam mark_t MarkHighlight = 2'd2;
  localparam mark_t MarkOther     = 2'd3;

  localparam logic [CfgIdxWidth-1:0] RegNowX  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegNowY  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegNowZ  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegLastX = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegLastY = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegLastZ = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegRadius = 3'd6;
  localparam logic [CfgIdxWidth-1:0] RegClear = 3'd7;

  localparam int InWidth  = 56;
  localparam int OutWidth = 8;

endpackage
`default_nettype wire

// ===== src/brush_point_cylinder_select.sv =====
// brush sweep point select
// input stream s_axis: one cloud point with its current mark per transfer
// output stream m_axis: the new mark, a changed flag and a hit flag
// config: cfg_we/cfg_idx/cfg_data write the cursor positions, radius and
// clear mode; write only while no point is in flight
// pipeline of seven register stages: a point taken at one edge can leave as
// a result transfer at the seventh edge after it, one point per cycle sustained
// stage 1 differences and box test, stage 2 squares and axis products,
// stage 3 sums, stage 4 sphere test and cylinder operands, stage 5 partial
// products, stage 6 product sums, stage 7 compare and output register
// the whole pipeline advances together; while the output stage holds a result
// and the receiver holds tready low, every stage holds and s_axis_tready is low
// reset (rst, synchronous) clears all valid bits and the config registers
`default_nettype none
module brush_point_cylinder_select (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bpcs_pkg::CfgIdxWidth-1:0]  cfg_idx,
  input  wire logic [bpcs_pkg::CfgDataWidth-1:0] cfg_data,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // point_x, point_y, point_z, mark_in, zero fill
  input  wire logic [bpcs_pkg::InWidth-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // mark_out, changed, hit, zero fill
  output logic [bpcs_pkg::OutWidth-1:0]      m_axis_tdata
);
  import bpcs_pkg::*;

  coord_t now_c [3];
  coord_t last_c [3];
  logic [RadWidth-1:0] radius;
  logic clear_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        now_c[i] <= '0;
        last_c[i] <= '0;
      end
      radius <= '0;
      clear_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegNowX:   now_c[0] <= cfg_data;
        RegNowY:   now_c[1] <= cfg_data;
        RegNowZ:   now_c[2] <= cfg_data;
        RegLastX:  last_c[0] <= cfg_data;
        RegLastY:  last_c[1] <= cfg_data;
        RegLastZ:  last_c[2] <= cfg_data;
        RegRadius: radius <= cfg_data[RadWidth-1:0];
        RegClear:  clear_mode <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  // derived constants of the configuration, stable while points flow
  diff_t d_c [3];
  logic same;
  always_comb begin
    for (int i = 0; i < 3; i++)
      d_c[i] = DiffWidth'(last_c[i]) - DiffWidth'(now_c[i]);
    same = (now_c[0] == last_c[0]) && (now_c[1] == last_c[1]) &&
           (now_c[2] == last_c[2]);
  end

  logic [6:0] vld;
  logic adv;
  assign adv = !vld[6] || m_axis_tready;
  assign s_axis_tready = adv;
  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  coord_t pt [3];
  mark_t mark_in;
  assign pt[0] = s_axis_tdata[15:0];
  assign pt[1] = s_axis_tdata[31:16];
  assign pt[2] = s_axis_tdata[47:32];
  assign mark_in = s_axis_tdata[49:48];

  // stage 1
  diff_t q1 [3];
  logic out1;
  mark_t mk1;
  logic out_c;
  always_comb begin
    out_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      diff_t lo, hi, p;
      p = DiffWidth'(pt[i]);
      lo = (now_c[i] < last_c[i]) ? DiffWidth'(now_c[i]) : DiffWidth'(last_c[i]);
      hi = (now_c[i] > last_c[i]) ? DiffWidth'(now_c[i]) : DiffWidth'(last_c[i]);
      lo = lo - DiffWidth'({1'b0, radius});
      hi = hi + DiffWidth'({1'b0, radius});
      if (p < lo || p > hi) out_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) q1[i] <= DiffWidth'(pt[i]) - DiffWidth'(now_c[i]);
      out1 <= out_c;
      mk1 <= mark_in;
    end
  end

  // stage 2: squares and axis products
  logic signed [SqWidth-1:0] qq2 [3];
  logic signed [SqWidth-1:0] qd2 [3];
  logic signed [SqWidth-1:0] dd2 [3];
  logic out2;
  mark_t mk2;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        qq2[i] <= q1[i] * q1[i];
        qd2[i] <= q1[i] * d_c[i];
        dd2[i] <= d_c[i] * d_c[i];
      end
      out2 <= out1;
      mk2 <= mk1;
    end
  end

  // stage 3: sums
  logic [Dist2Width-1:0] dist3, len3;
  logic signed [DotWidth-1:0] dot3;
  logic out3;
  mark_t mk3;
  always_ff @(posedge clk) begin
    if (adv) begin
      dist3 <= Dist2Width'(unsigned'(qq2[0])) + Dist2Width'(unsigned'(qq2[1]))
             + Dist2Width'(unsigned'(qq2[2]));
      len3 <= Dist2Width'(unsigned'(dd2[0])) + Dist2Width'(unsigned'(dd2[1]))
            + Dist2Width'(unsigned'(dd2[2]));
      dot3 <= DotWidth'(qd2[0]) + DotWidth'(qd2[1]) + DotWidth'(qd2[2]);
      out3 <= out2;
      mk3 <= mk2;
    end
  end

  // stage 4: sphere test and operands of the cylinder compare
  // the cylinder holds the point when (dist2 - r2) * len2 <= dot * dot
  logic [2*RadWidth-1:0] r2;
  assign r2 = radius * radius;
  logic [MulWidth-1:0] ex4, len4, dot4;
  logic sph4, axok4, out4;
  mark_t mk4;
  always_ff @(posedge clk) begin
    if (adv) begin
      sph4 <= dist3 <= Dist2Width'(r2);
      axok4 <= !dot3[DotWidth-1] && (unsigned'(dot3) <= DotWidth'(len3));
      // only used when the sphere misses, so never negative there
      ex4 <= MulWidth'(dist3 - Dist2Width'(r2));
      len4 <= len3[MulWidth-1:0];
      dot4 <= dot3[MulWidth-1:0];
      out4 <= out3;
      mk4 <= mk3;
    end
  end

  // stage 5: partial products on half-width operands
  logic [2*HalfWidth-1:0] el_hh5, el_hl5, el_lh5, el_ll5;
  logic [2*HalfWidth-1:0] dd_hh5, dd_hl5, dd_ll5;
  logic sph5, cyl5, out5;
  mark_t mk5;
  always_ff @(posedge clk) begin
    if (adv) begin
      el_hh5 <= ex4[MulWidth-1:HalfWidth] * len4[MulWidth-1:HalfWidth];
      el_hl5 <= ex4[MulWidth-1:HalfWidth] * len4[HalfWidth-1:0];
      el_lh5 <= ex4[HalfWidth-1:0] * len4[MulWidth-1:HalfWidth];
      el_ll5 <= ex4[HalfWidth-1:0] * len4[HalfWidth-1:0];
      dd_hh5 <= dot4[MulWidth-1:HalfWidth] * dot4[MulWidth-1:HalfWidth];
      dd_hl5 <= dot4[MulWidth-1:HalfWidth] * dot4[HalfWidth-1:0];
      dd_ll5 <= dot4[HalfWidth-1:0] * dot4[HalfWidth-1:0];
      sph5 <= sph4;
      cyl5 <= !same && axok4;
      out5 <= out4;
      mk5 <= mk4;
    end
  end

  // stage 6: full products
  logic [ProdWidth-1:0] lhs6, rhs6;
  logic sph6, cyl6, out6;
  mark_t mk6;
  always_ff @(posedge clk) begin
    if (adv) begin
      lhs6 <= {el_hh5, el_ll5} + (ProdWidth'(el_hl5) << HalfWidth)
            + (ProdWidth'(el_lh5) << HalfWidth);
      // cross term of the square appears twice
      rhs6 <= {dd_hh5, dd_ll5} + (ProdWidth'(dd_hl5) << (HalfWidth + 1));
      sph6 <= sph5;
      cyl6 <= cyl5;
      out6 <= out5;
      mk6 <= mk5;
    end
  end

  // stage 7: final decision and output register
  mark_t mk_o;
  logic chg_o, hit_o;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (mk6 == MarkCleaned) begin
        mk_o <= MarkCleaned; chg_o <= 1'b0; hit_o <= 1'b0;
      end else if (!out6 && (sph6 || (cyl6 && lhs6 <= rhs6))) begin
        mk_o <= clear_mode ? MarkCleaned : MarkHighlight;
        chg_o <= 1'b1; hit_o <= clear_mode;
      end else begin
        mk_o <= MarkNone; chg_o <= (mk6 != MarkNone); hit_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[5:0], in_xfer};
  end

  assign m_axis_tvalid = vld[6];
  assign m_axis_tdata = {4'b0, hit_o, chg_o, mk_o};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[1:0] == MarkCleaned && m_axis_tdata[2])
    else $error("hit without clean");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    vld[6] && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while full");

endmodule
`default_nettype wire
